[src/crc_pkg.sv]
// ----------------------------------------------------------------------------
// crc_pkg
// Shared constants, register map, configuration struct and the bit-level
// helper functions of the configurable CRC engine.
// ----------------------------------------------------------------------------
package crc_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned BYTES      = DATA_W / 8;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  // Width codes (code three behaves as 32 bits)
  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_32 = 2'd2;

  // Register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_WIDTH_CODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_POLY        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INIT_VALUE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REFLECT_IN  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REFLECT_OUT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FINAL_XOR   = 3'd5;

  localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]       width_code;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] init_value;
    logic             reflect_in;
    logic             reflect_out;
    logic [CRC_W-1:0] final_xor;
  } crc_cfg_t;

  // Mask of the active CRC width
  function automatic logic [CRC_W-1:0] crc_mask(input logic [1:0] wcode);
    logic [CRC_W-1:0] m;
    case (wcode)
      WCODE_8:  m = 32'h0000_00FF;
      WCODE_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Bit-reverse one byte
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // Reverse the low width bits; upper bits come out zero
  function automatic logic [CRC_W-1:0] rev_width(input logic [CRC_W-1:0] v,
                                                 input logic [1:0]       wcode);
    logic [CRC_W-1:0] full;
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) begin
      full[i] = v[CRC_W-1-i];
    end
    case (wcode)
      WCODE_8:  r = full >> (CRC_W - 8);
      WCODE_16: r = full >> (CRC_W - 16);
      default:  r = full;
    endcase
    return r;
  endfunction

  // Shift one byte MSB-first into a masked CRC register
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       din_byte,
                                                input logic [1:0]       wcode,
                                                input logic [CRC_W-1:0] poly_m,
                                                input logic [CRC_W-1:0] mask);
    logic [CRC_W-1:0] r;
    logic             top;
    r = crc_in;
    for (int i = 7; i >= 0; i--) begin
      case (wcode)
        WCODE_8:  top = r[7];
        WCODE_16: top = r[15];
        default:  top = r[CRC_W-1];
      endcase
      r = (r << 1) & mask;
      if (top ^ din_byte[i]) begin
        r = r ^ poly_m;
      end
    end
    return r;
  endfunction

endpackage

[src/crc_if.sv]
// ----------------------------------------------------------------------------
// crc_in_if / crc_out_if
// Valid/ready channels for data words into the engine and CRC results out.
// ----------------------------------------------------------------------------
interface crc_in_if;
  logic                             valid;
  logic                             ready;
  logic [crc_pkg::DATA_W-1:0]       data_word;
  logic [crc_pkg::COUNT_W-1:0]      byte_count;
  logic                             start_req;

  modport source (output valid, output data_word, output byte_count,
                  output start_req, input ready);
  modport sink   (input valid, input data_word, input byte_count,
                  input start_req, output ready);
endinterface

interface crc_out_if;
  logic                       valid;
  logic                       ready;
  logic [crc_pkg::CRC_W-1:0]  crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

[src/crc_regs.sv]
// ----------------------------------------------------------------------------
// crc_regs
// APB register file holding the CRC configuration; writes complete in the
// access phase, reads return the stored value zero-extended.
// ----------------------------------------------------------------------------
module crc_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crc_pkg::ADDR_W-1:0]       paddr,
  input  logic [crc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [crc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output crc_pkg::crc_cfg_t                cfg
);
  import crc_pkg::*;

  crc_cfg_t              cfg_q;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg     = cfg_q;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.width_code  <= WCODE_32;
      cfg_q.poly        <= POLY_RESET;
      cfg_q.init_value  <= INIT_RESET;
      cfg_q.reflect_in  <= 1'b0;
      cfg_q.reflect_out <= 1'b0;
      cfg_q.final_xor   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH_CODE:  cfg_q.width_code  <= pwdata[1:0];
        REG_POLY:        cfg_q.poly        <= pwdata;
        REG_INIT_VALUE:  cfg_q.init_value  <= pwdata;
        REG_REFLECT_IN:  cfg_q.reflect_in  <= pwdata[0];
        REG_REFLECT_OUT: cfg_q.reflect_out <= pwdata[0];
        REG_FINAL_XOR:   cfg_q.final_xor   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_WIDTH_CODE:  prdata = {30'd0, cfg_q.width_code};
      REG_POLY:        prdata = cfg_q.poly;
      REG_INIT_VALUE:  prdata = cfg_q.init_value;
      REG_REFLECT_IN:  prdata = {31'd0, cfg_q.reflect_in};
      REG_REFLECT_OUT: prdata = {31'd0, cfg_q.reflect_out};
      REG_FINAL_XOR:   prdata = cfg_q.final_xor;
      default:         prdata = '0;
    endcase
  end

endmodule

[src/configurable_crc_engine.sv]
// ----------------------------------------------------------------------------
// configurable_crc_engine
// CRC-8/16/32 engine with programmable polynomial, seed, reflection and
// final XOR, fed one little-endian word of 0 to 4 bytes per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready; data_word (byte 0 in bits 7:0), byte_count and
//            start_req. start_req reloads the CRC with init_value first.
//   out_ch : valid/ready; one crc_value per input transaction, in order.
//   APB    : six 32-bit registers at 0x00..0x14, pready tied high. Change
//            them only while no transaction is in flight.
//   Path: input register, then the unrolled 32-bit CRC update into the result
//            register.
//   Throughput: one word per cycle while out_ch is not held; the CRC register
//            feedback through the four chained byte updates sets that figure.
//   Reset: clears the valid flags of both pipeline stages and the CRC register to zero and
//            loads the register defaults (CRC-32 polynomial, all-ones seed).
//   Stall: while out_ch is held, one more word is taken into the input
//            register, then in_ch.ready drops until the result drains.
// ----------------------------------------------------------------------------
module configurable_crc_engine (
  input  logic                             clk,
  input  logic                             rst,
  crc_in_if.sink                           in_ch,
  crc_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crc_pkg::ADDR_W-1:0]       paddr,
  input  logic [crc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [crc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import crc_pkg::*;

  crc_cfg_t            cfg;

  // Input stage
  logic                s1_valid;
  logic [DATA_W-1:0]   s1_data;
  logic [COUNT_W-1:0]  s1_count;
  logic                s1_start;

  // Result stage and running CRC
  logic                out_valid;
  logic [CRC_W-1:0]    out_crc;
  logic [CRC_W-1:0]    crc_register;

  logic                load_out;
  logic [CRC_W-1:0]    mask;
  logic [CRC_W-1:0]    poly_m;
  logic [CRC_W-1:0]    chain [BYTES+1];
  logic [CRC_W-1:0]    crc_register_next;
  logic [CRC_W-1:0]    refl;
  logic [CRC_W-1:0]    out_crc_next;
  logic [7:0]          din;

  crc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: result register frees up when empty or being taken
  assign load_out     = s1_valid & (~out_valid | out_ch.ready);
  assign in_ch.ready  = ~s1_valid | load_out;
  assign out_ch.valid = out_valid;
  assign out_ch.crc_value = out_crc;

  // Byte-wise CRC update over the valid bytes
  always_comb begin
    mask   = crc_mask(cfg.width_code);
    poly_m = cfg.poly & mask;
    din    = '0;
    chain[0] = s1_start ? (cfg.init_value & mask) : (crc_register & mask);
    for (int k = 0; k < BYTES; k++) begin
      din = s1_data[8*k +: 8];
      if (cfg.reflect_in) begin
        din = rev8(din);
      end
      chain[k+1] = crc_byte(chain[k], din, cfg.width_code, poly_m, mask);
    end
    case (s1_count)
      3'd0:    crc_register_next = chain[0];
      3'd1:    crc_register_next = chain[1];
      3'd2:    crc_register_next = chain[2];
      3'd3:    crc_register_next = chain[3];
      default: crc_register_next = chain[BYTES];
    endcase
  end

  // Output reflection and final XOR
  always_comb begin
    refl = cfg.reflect_out ? rev_width(crc_register_next, cfg.width_code)
                           : crc_register_next;
    out_crc_next = (refl ^ cfg.final_xor) & mask;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      crc_register <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (load_out) begin
        out_valid    <= 1'b1;
        crc_register <= crc_register_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data  <= in_ch.data_word;
      s1_count <= in_ch.byte_count;
      s1_start <= in_ch.start_req;
    end
    if (load_out) begin
      out_crc <= out_crc_next;
    end
  end

endmodule
